// File: design/pit3_pkg.sv
`default_nettype none
package pit3_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_GATE  = 2'd3
  } req_t;

  localparam logic [1:0] ADDR_CTRL = 2'd3;
  localparam logic [16:0] FULL_EMPTY = 17'h10000;
  localparam logic [16:0] TC_ADD = 17'h0FFFF;

  typedef struct packed {
    logic [15:0] reload;
    logic [16:0] count;
    logic [2:0]  mode;
    logic [1:0]  rphase;
    logic [1:0]  wphase;
    logic [16:0] latch;
    logic        outs;
    logic        gate;
    logic        enabled;
    logic        thit;
    logic        initial_f;
    logic        pend;
    logic        disabled;
    logic        held;
    logic        relatch;
  } chan_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] addr;
    logic [7:0] write_data;
    logic [1:0] channel;
    logic       gate_in;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_level_zero;
    logic       out_level_one;
    logic       out_level_two;
  } res_item_t;

endpackage
`default_nettype wire

// File: design/pit3_if.sv
`default_nettype none
interface pit3_req_if;
  logic                 valid;
  logic                 ready;
  pit3_pkg::req_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pit3_res_if;
  logic                 valid;
  logic                 ready;
  pit3_pkg::res_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/pit3_chan.sv
`default_nettype none
// Next state of one channel for one request, plus the read byte.
module pit3_chan (
  input  wire pit3_pkg::chan_t  cur,
  input  wire logic             do_ctrl,
  input  wire logic             do_wr,
  input  wire logic             do_rd,
  input  wire logic             do_tick,
  input  wire logic             do_gate,
  input  wire logic [7:0]       wdata,
  input  wire logic             gate_in,
  output pit3_pkg::chan_t       nxt,
  output logic [7:0]            rdata
);
  logic [16:0] full;
  logic [16:0] cur_cnt;
  logic [16:0] dec;
  logic [16:0] add;
  logic [16:0] full_rel;
  logic [2:0]  m;
  logic        rise;

  always_comb begin
    nxt = cur;
    rdata = 8'd0;
    full = (cur.reload == 16'd0) ? pit3_pkg::FULL_EMPTY : {1'b0, cur.reload};
    cur_cnt = (cur.mode == 3'd2) ? cur.count + 17'd1 : cur.count;
    full_rel = (cur.mode == 3'd2) ? full - 17'd1 : full;
    dec = 17'd0;
    add = pit3_pkg::TC_ADD;
    m = 3'd0;
    rise = gate_in & ~cur.gate;

    if (do_ctrl) begin
      if (wdata[5:4] == 2'b00) begin
        nxt.latch = cur_cnt;
        nxt.relatch = 1'b0;
        nxt.rphase = 2'd3;
        nxt.held = 1'b1;
      end else begin
        nxt.rphase = wdata[5:4];
        nxt.wphase = wdata[5:4];
        m = wdata[3:1];
        if (m > 3'd5) m = {1'b0, m[1:0]};
        nxt.mode = m;
        nxt.relatch = 1'b1;
        nxt.initial_f = 1'b1;
        nxt.outs = (m != 3'd0);
        nxt.disabled = 1'b1;
      end
      nxt.thit = 1'b0;
    end

    if (do_wr) begin
      case (cur.wphase)
        2'd1: nxt.reload = {8'd0, wdata};
        2'd2: nxt.reload = {wdata, 8'd0};
        2'd0: begin
          nxt.reload = {wdata, cur.reload[7:0]};
          nxt.wphase = 2'd3;
        end
        default: begin
          nxt.reload = {cur.reload[15:8], wdata};
          nxt.wphase = 2'd0;
        end
      endcase
      if (cur.wphase != 2'd3) begin
        full = (nxt.reload == 16'd0) ? pit3_pkg::FULL_EMPTY : {1'b0, nxt.reload};
        nxt.pend = 1'b0;
        nxt.disabled = 1'b0;
        case (cur.mode)
          3'd0: begin
            nxt.count = full;
            nxt.outs = 1'b0;
            nxt.thit = 1'b0;
            nxt.enabled = cur.gate;
          end
          3'd2, 3'd3: begin
            if (cur.initial_f) begin
              nxt.count = (cur.mode == 3'd2) ? full - 17'd1 : full;
              nxt.outs = 1'b1;
              nxt.thit = 1'b0;
            end
            nxt.enabled = cur.gate;
          end
          3'd4: begin
            if (!cur.thit && !cur.initial_f) begin
              nxt.pend = 1'b1;
            end else begin
              nxt.count = full;
              nxt.outs = 1'b0;
              nxt.thit = 1'b0;
            end
            nxt.enabled = cur.gate;
          end
          default: nxt.enabled = 1'b1;
        endcase
        nxt.initial_f = 1'b0;
      end
    end

    if (do_rd) begin
      if (cur.relatch && !cur.held) begin
        nxt.relatch = 1'b0;
        nxt.latch = cur_cnt;
      end
      case (cur.rphase)
        2'd0, 2'd2: begin
          rdata = nxt.latch[15:8];
          if (cur.rphase == 2'd0) nxt.rphase = 2'd3;
          nxt.held = 1'b0;
          nxt.relatch = 1'b1;
        end
        2'd1: begin
          rdata = nxt.latch[7:0];
          nxt.held = 1'b0;
          nxt.relatch = 1'b1;
        end
        default: begin
          rdata = nxt.latch[7:0];
          nxt.rphase = 2'd0;
        end
      endcase
    end

    if (do_tick && !cur.thit && cur.enabled) begin
      if (cur.mode == 3'd3) dec = (cur.count <= 17'd2) ? 17'd0 : cur.count - 17'd2;
      else dec = cur.count - 17'd1;
      nxt.count = dec;
      if (dec == 17'd0) begin
        if (!cur.disabled) begin
          case (cur.mode)
            3'd2: begin
              add = full;
              nxt.outs = 1'b1;
            end
            3'd3: begin
              add = full;
              nxt.outs = ~cur.outs;
            end
            3'd4: begin
              if (!cur.thit) nxt.outs = 1'b1;
              if (cur.pend) begin
                nxt.pend = 1'b0;
                add = full;
              end else begin
                nxt.thit = 1'b1;
              end
            end
            default: begin
              nxt.outs = 1'b1;
              nxt.thit = 1'b1;
            end
          endcase
        end
        nxt.count = add;
      end
    end

    if (do_gate) begin
      if (!cur.disabled) begin
        case (cur.mode)
          3'd0, 3'd4: nxt.enabled = gate_in;
          3'd1, 3'd5: begin
            if (rise) begin
              nxt.count = full;
              nxt.outs = 1'b0;
              nxt.thit = 1'b0;
              nxt.enabled = 1'b1;
            end
          end
          default: begin
            if (rise) begin
              nxt.count = full_rel;
              nxt.outs = 1'b1;
              nxt.thit = 1'b0;
            end
            nxt.enabled = gate_in;
          end
        endcase
      end
      nxt.gate = gate_in;
    end
  end
endmodule
`default_nettype wire

// File: design/interval_timer_three_channel.sv
`default_nettype none
// Three-counter interval timer, 8253 style.
// in_ channel: one request per item: a bus write (control word at address 3,
//   counter byte at 0-2), a bus read, one counter clock tick, or a gate
//   level change for the given channel.
// out_ channel: one result per request: the read byte (zero unless a read)
//   and the three output levels after the request.
// Pipeline: the request is registered at the input, then its result is registered
//   and shown on the out_ channel. Throughput: one request per cycle while
//   out_ready is high; the channel state update is one pass of logic between
//   the input register and the result register.
// Reset: counters idle, reload 0xFFFF, gates high/high/low, all outputs low.
// Stall: when out_ready is low the result holds; one more request may enter
//   the input register, then in_ready drops until the result is taken.
module interval_timer_three_channel #(
  parameter int NUM_CHANNELS = 3
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pit3_req_if.sink     in_ch,
  pit3_res_if.source   out_ch
);
  localparam int NCH = 3;

  pit3_pkg::chan_t     ch_r [NCH];
  pit3_pkg::chan_t     ch_nxt [NCH];
  logic [7:0]          rd_ch [NCH];
  pit3_pkg::req_item_t req_r;
  logic                req_v_r;
  pit3_pkg::res_item_t res_r;
  pit3_pkg::res_item_t res_nxt;
  logic                res_v_r;
  logic [7:0]          ctl_r;
  logic [7:0]          ctl_nxt;
  logic                adv;
  logic                cw_ok;

  function automatic pit3_pkg::chan_t chan_rst_val(int idx);
    pit3_pkg::chan_t v;
    v = '0;
    v.reload = 16'hFFFF;
    v.gate = (idx < 2);
    v.thit = (idx == 0);
    return v;
  endfunction

  assign adv = req_v_r && (!res_v_r || out_ch.ready);
  assign in_ch.ready = !req_v_r || adv;
  assign out_ch.valid = res_v_r;
  assign out_ch.data = res_r;
  assign cw_ok = (32'(req_r.write_data[7:6]) < NUM_CHANNELS);

  for (genvar i = 0; i < NCH; i++) begin : g_ch
    logic is_w, is_r, ok;
    assign ok = (i < NUM_CHANNELS);
    assign is_w = req_r.req_type == pit3_pkg::REQ_WRITE;
    assign is_r = req_r.req_type == pit3_pkg::REQ_READ;
    pit3_chan u_chan (
      .cur     (ch_r[i]),
      .do_ctrl (ok && is_w && req_r.addr == pit3_pkg::ADDR_CTRL
                && req_r.write_data[7:6] == 2'(i)),
      .do_wr   (ok && is_w && req_r.addr == 2'(i)),
      .do_rd   (ok && is_r && req_r.addr == 2'(i)),
      .do_tick (ok && req_r.req_type == pit3_pkg::REQ_TICK && req_r.channel == 2'(i)),
      .do_gate (ok && req_r.req_type == pit3_pkg::REQ_GATE && req_r.channel == 2'(i)),
      .wdata   (req_r.write_data),
      .gate_in (req_r.gate_in),
      .nxt     (ch_nxt[i]),
      .rdata   (rd_ch[i])
    );
  end

  always_comb begin
    ctl_nxt = ctl_r;
    if (req_r.req_type == pit3_pkg::REQ_WRITE && req_r.addr == pit3_pkg::ADDR_CTRL
        && cw_ok) begin
      ctl_nxt = (req_r.write_data[5:4] == 2'b00) ? (req_r.write_data | 8'h30)
                                                 : req_r.write_data;
    end
    res_nxt.read_data = 8'd0;
    if (req_r.req_type == pit3_pkg::REQ_READ) begin
      if (req_r.addr == pit3_pkg::ADDR_CTRL) res_nxt.read_data = ctl_r;
      else if (32'(req_r.addr) < NUM_CHANNELS) res_nxt.read_data = rd_ch[req_r.addr];
    end
    res_nxt.out_level_zero = ch_nxt[0].outs && (NUM_CHANNELS > 0);
    res_nxt.out_level_one  = ch_nxt[1].outs && (NUM_CHANNELS > 1);
    res_nxt.out_level_two  = ch_nxt[2].outs && (NUM_CHANNELS > 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      res_v_r <= 1'b0;
      ctl_r <= 8'd0;
      for (int i = 0; i < NCH; i++) ch_r[i] <= chan_rst_val(i);
    end else begin
      if (in_ch.valid && in_ch.ready) req_v_r <= 1'b1;
      else if (adv) req_v_r <= 1'b0;
      if (adv) begin
        res_v_r <= 1'b1;
        ctl_r <= ctl_nxt;
        for (int i = 0; i < NCH; i++) ch_r[i] <= ch_nxt[i];
      end else if (out_ch.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    if (adv) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// File: sim/tb_interval_timer_three_channel.sv
`timescale 1ns / 100ps
module tb_interval_timer_three_channel;

  logic clk;
  logic rst_n;

  pit3_req_if req_bus ();
  pit3_res_if res_bus ();

  interval_timer_three_channel #(.NUM_CHANNELS(3)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_bus.sink),
    .out_ch(res_bus.source)
  );

  // timer state mirror
  logic [15:0] t_reload  [3];
  logic [16:0] t_count   [3];
  logic [2:0]  t_mode    [3];
  logic [1:0]  t_rphase  [3];
  logic [1:0]  t_wphase  [3];
  logic [16:0] t_latch   [3];
  logic        t_outs    [3];
  logic        t_gate    [3];
  logic        t_enabled [3];
  logic        t_thit    [3];
  logic        t_init    [3];
  logic        t_pend    [3];
  logic        t_disabled[3];
  logic        t_held    [3];
  logic        t_relatch [3];
  logic [7:0]  t_last_ctrl;

  pit3_pkg::res_item_t expected_results[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  function automatic logic [16:0] full_count(int c);
    return (t_reload[c] == 16'd0) ? pit3_pkg::FULL_EMPTY : {1'b0, t_reload[c]};
  endfunction

  function automatic logic [16:0] live_count(int c);
    return (t_mode[c] == 3'd2) ? t_count[c] + 17'd1 : t_count[c];
  endfunction

  task automatic timer_reset();
    for (int c = 0; c < 3; c++) begin
      t_reload[c] = 16'hFFFF; t_count[c] = '0; t_mode[c] = '0;
      t_rphase[c] = '0; t_wphase[c] = '0; t_latch[c] = '0; t_outs[c] = 0;
      t_enabled[c] = 0; t_thit[c] = 0; t_init[c] = 0; t_pend[c] = 0;
      t_disabled[c] = 0; t_held[c] = 0; t_relatch[c] = 0;
    end
    t_gate[0] = 1; t_gate[1] = 1; t_gate[2] = 0;
    t_thit[0] = 1;
    t_last_ctrl = '0;
  endtask

  task automatic start_count(int c);
    logic [16:0] l;
    l = full_count(c);
    t_pend[c] = 0;
    t_disabled[c] = 0;
    case (t_mode[c])
      3'd0: begin
        t_count[c] = l; t_outs[c] = 0; t_thit[c] = 0; t_enabled[c] = t_gate[c];
      end
      3'd2, 3'd3: begin
        if (t_init[c]) begin
          t_count[c] = (t_mode[c] == 3'd2) ? l - 17'd1 : l;
          t_outs[c] = 1; t_thit[c] = 0;
        end
        t_enabled[c] = t_gate[c];
      end
      3'd4: begin
        if (!t_thit[c] && !t_init[c]) begin
          t_pend[c] = 1;
        end else begin
          t_count[c] = l; t_outs[c] = 0; t_thit[c] = 0;
        end
        t_enabled[c] = t_gate[c];
      end
      default: t_enabled[c] = 1;
    endcase
    t_init[c] = 0;
  endtask

  task automatic terminal_count(int c);
    logic [16:0] add;
    add = pit3_pkg::TC_ADD;
    if (t_disabled[c]) begin
      t_count[c] = t_count[c] + add;
      return;
    end
    case (t_mode[c])
      3'd2: begin add = full_count(c); t_outs[c] = 1; end
      3'd3: begin add = full_count(c); t_outs[c] = !t_outs[c]; end
      3'd4: begin
        if (!t_thit[c]) t_outs[c] = 1;
        if (t_pend[c]) begin
          t_pend[c] = 0; add = full_count(c);
        end else begin
          t_thit[c] = 1;
        end
      end
      default: begin
        if (!t_thit[c]) t_outs[c] = 1;
        t_thit[c] = 1;
      end
    endcase
    t_count[c] = t_count[c] + add;
  endtask

  task automatic clock_tick(int c);
    if (t_thit[c] || !t_enabled[c]) return;
    if (t_mode[c] == 3'd3) t_count[c] = (t_count[c] <= 17'd2) ? 17'd0 : t_count[c] - 17'd2;
    else t_count[c] = t_count[c] - 17'd1;
    if (t_count[c] == 17'd0) terminal_count(c);
  endtask

  task automatic gate_change(int c, logic g);
    logic [16:0] l;
    logic rise;
    l = full_count(c);
    rise = g && !t_gate[c];
    if (!t_disabled[c]) begin
      case (t_mode[c])
        3'd0, 3'd4: t_enabled[c] = g;
        3'd1, 3'd5: begin
          if (rise) begin
            t_count[c] = l; t_outs[c] = 0; t_thit[c] = 0; t_enabled[c] = 1;
          end
        end
        default: begin
          if (rise) begin
            t_count[c] = (t_mode[c] == 3'd2) ? l - 17'd1 : l;
            t_outs[c] = 1; t_thit[c] = 0;
          end
          t_enabled[c] = g;
        end
      endcase
    end
    t_gate[c] = g;
  endtask

  task automatic control_word(logic [7:0] v);
    int c;
    logic [2:0] m;
    c = int'(v[7:6]);
    if (c >= 3) return;
    t_last_ctrl = v;
    if (v[5:4] == 2'b00) begin
      t_latch[c] = live_count(c);
      t_last_ctrl = v | 8'h30;
      t_relatch[c] = 0; t_rphase[c] = 2'd3; t_held[c] = 1;
    end else begin
      t_rphase[c] = v[5:4]; t_wphase[c] = v[5:4];
      m = v[3:1];
      if (m > 3'd5) m = m & 3'd3;
      t_mode[c] = m;
      t_relatch[c] = 1; t_init[c] = 1;
      t_outs[c] = (m != 3'd0); t_disabled[c] = 1;
    end
    t_thit[c] = 0;
  endtask

  task automatic data_write(int c, logic [7:0] v);
    case (t_wphase[c])
      2'd1: begin t_reload[c] = {8'h00, v}; start_count(c); end
      2'd2: begin t_reload[c] = {v, 8'h00}; start_count(c); end
      2'd0: begin
        t_reload[c] = {v, t_reload[c][7:0]}; start_count(c); t_wphase[c] = 2'd3;
      end
      default: begin t_reload[c] = {t_reload[c][15:8], v}; t_wphase[c] = 2'd0; end
    endcase
  endtask

  task automatic data_read(int c, output logic [7:0] r);
    if (t_relatch[c] && !t_held[c]) begin
      t_relatch[c] = 0; t_latch[c] = live_count(c);
    end
    case (t_rphase[c])
      2'd0, 2'd2: begin
        r = t_latch[c][15:8];
        if (t_rphase[c] == 2'd0) t_rphase[c] = 2'd3;
        t_held[c] = 0; t_relatch[c] = 1;
      end
      2'd1: begin r = t_latch[c][7:0]; t_held[c] = 0; t_relatch[c] = 1; end
      default: begin r = t_latch[c][7:0]; t_rphase[c] = 2'd0; end
    endcase
  endtask

  task automatic timer_step(input pit3_pkg::req_item_t it, output pit3_pkg::res_item_t r);
    logic [7:0] rd;
    rd = '0;
    case (pit3_pkg::req_t'(it.req_type))
      pit3_pkg::REQ_WRITE: begin
        if (it.addr == pit3_pkg::ADDR_CTRL) control_word(it.write_data);
        else if (it.addr < 3) data_write(int'(it.addr), it.write_data);
      end
      pit3_pkg::REQ_READ: begin
        if (it.addr == pit3_pkg::ADDR_CTRL) rd = t_last_ctrl;
        else if (it.addr < 3) data_read(int'(it.addr), rd);
      end
      pit3_pkg::REQ_TICK: if (it.channel < 3) clock_tick(int'(it.channel));
      default: if (it.channel < 3) gate_change(int'(it.channel), it.gate_in);
    endcase
    r.read_data = rd;
    r.out_level_zero = t_outs[0];
    r.out_level_one = t_outs[1];
    r.out_level_two = t_outs[2];
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stall plus a counted long hold-off
  initial begin
    res_bus.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res_bus.ready <= 0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_bus.data);
        errors++;
      end else begin
        pit3_pkg::res_item_t e;
        e = expected_results.pop_front();
        if (res_bus.data.read_data !== e.read_data)
          begin $display("%0t: read_data exp %h got %h", $time, e.read_data,
                         res_bus.data.read_data); errors++; end
        if (res_bus.data.out_level_zero !== e.out_level_zero)
          begin $display("%0t: out0 exp %b got %b", $time, e.out_level_zero,
                         res_bus.data.out_level_zero); errors++; end
        if (res_bus.data.out_level_one !== e.out_level_one)
          begin $display("%0t: out1 exp %b got %b", $time, e.out_level_one,
                         res_bus.data.out_level_one); errors++; end
        if (res_bus.data.out_level_two !== e.out_level_two)
          begin $display("%0t: out2 exp %b got %b", $time, e.out_level_two,
                         res_bus.data.out_level_two); errors++; end
      end
    end
  end

  // valid stays high between back-to-back requests; drain() drops it
  task automatic send_request(pit3_pkg::req_item_t it);
    pit3_pkg::res_item_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 0;
      @(negedge clk);
    end
    req_bus.valid <= 1;
    req_bus.data <= it;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    timer_step(it, exp_r);
    expected_results.push_back(exp_r);
    @(negedge clk);
  endtask

  function automatic pit3_pkg::req_item_t make_req(pit3_pkg::req_t k, logic [1:0] a,
                                                   logic [7:0] d, logic [1:0] ch, logic g);
    pit3_pkg::req_item_t it;
    it.req_type = k; it.addr = a; it.write_data = d; it.channel = ch; it.gate_in = g;
    return it;
  endfunction

  task automatic bus_write(logic [1:0] a, logic [7:0] d);
    send_request(make_req(pit3_pkg::REQ_WRITE, a, d, 2'($urandom), 1'($urandom)));
  endtask

  task automatic drain();
    req_bus.valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    bus_write(pit3_pkg::ADDR_CTRL, 8'h36);   // ch0 mode 3 lo/hi
    bus_write(2'd0, 8'h05);
    bus_write(2'd0, 8'h00);
    for (int i = 0; i < 6; i++)
      send_request(make_req(pit3_pkg::REQ_TICK, 2'd0, 8'h00, 2'd0, 1'b0));
    bus_write(pit3_pkg::ADDR_CTRL, 8'h00);   // latch ch0
    send_request(make_req(pit3_pkg::REQ_READ, 2'd0, 8'hFF, 2'd0, 1'b0));
    send_request(make_req(pit3_pkg::REQ_READ, 2'd0, 8'hFF, 2'd0, 1'b0));
    send_request(make_req(pit3_pkg::REQ_READ, pit3_pkg::ADDR_CTRL, 8'h00, 2'd0, 1'b0));
    bus_write(pit3_pkg::ADDR_CTRL, 8'hFE);   // read-back: ignored
    bus_write(pit3_pkg::ADDR_CTRL, 8'h5E);   // ch1 mode 7 -> 3, lsb only
    bus_write(2'd1, 8'h00);
    bus_write(pit3_pkg::ADDR_CTRL, 8'hB8);   // ch2 mode 4 before count: disabled
    send_request(make_req(pit3_pkg::REQ_GATE, 2'd0, 8'h00, 2'd2, 1'b1));
    send_request(make_req(pit3_pkg::REQ_TICK, 2'd0, 8'h00, 2'd3, 1'b1));   // absent channel
    send_request(make_req(pit3_pkg::REQ_GATE, 2'd0, 8'h00, 2'd3, 1'b0));
    send_request(make_req(pit3_pkg::REQ_TICK, 2'd0, 8'h00, 2'd2, 1'b0));
    bus_write(2'd2, 8'hFF);
    bus_write(2'd2, 8'hFF);
    send_request(make_req(pit3_pkg::REQ_READ, 2'd2, 8'h00, 2'd0, 1'b0));
    drain();
  endtask

  function automatic pit3_pkg::req_item_t random_req();
    pit3_pkg::req_item_t it;
    int p;
    it = pit3_pkg::req_item_t'(13'($urandom));
    p = $urandom_range(99);
    if (p < 45) begin
      it.req_type = pit3_pkg::REQ_TICK; it.channel = 2'($urandom_range(2));
    end else if (p < 55) begin
      it.req_type = pit3_pkg::REQ_GATE;
    end else if (p < 75) begin
      it.req_type = pit3_pkg::REQ_READ;
    end else begin
      it.req_type = pit3_pkg::REQ_WRITE;
      // small counts so terminal counts happen often
      if (it.addr != pit3_pkg::ADDR_CTRL && $urandom_range(3) != 0)
        it.write_data = 8'($urandom_range(6));
    end
    return it;
  endfunction

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) begin
        // well-formed program: control word then count
        logic [1:0] ch;
        ch = 2'($urandom_range(2));
        bus_write(pit3_pkg::ADDR_CTRL, {ch, 2'($urandom_range(1, 3)), 3'($urandom), 1'b0});
        bus_write(ch, 8'($urandom_range(8)));
        bus_write(ch, 8'($urandom_range(1)));
      end else begin
        send_request(random_req());
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 60;
    for (int i = 0; i < 30; i++) send_request(random_req());
    drain();
    repeat (40) @(negedge clk);   // sender pauses with nothing outstanding
    test_random(20, 0, 0);
    drain();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 0;
    req_bus.valid = 0;
    req_bus.data = '0;
    timer_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 54, 0);
    test_random(250, 0, 54);
    test_random(200, 20, 20);
    test_backpressure();
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
